[src/mtf_pkg.sv]
// mtf_pkg: shared defaults, op codes and cell command type for the max tracking FIFO.
// No dependencies; used by mtf_cell, mtf_cand_chain and max_tracking_fifo.
package mtf_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 17;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic push;   // drop smaller candidates, append new value
        logic shift;  // remove front candidate, move row toward front
    } t_cell_cmd;

endpackage

[src/max_tracking_fifo.sv]
// max_tracking_fifo: FIFO that also reports the largest value it holds.
// Depends on mtf_pkg and mtf_cand_chain; value ring is a local memory.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | i_start, o_busy    | i_op, i_push_value
//  result   | o_done (1 cycle)   | o_popped_value, o_pop_was_empty,
//           |                    | o_push_dropped, o_current_max, o_max_valid,
//           |                    | o_occupancy
//
// A push, a dropped push and a pop on empty are handled in S_IDLE; the result strobes
// in the next cycle and a new item may start in that cycle. A pop of a held
// value passes through S_POP (o_busy high there): the ring memory read is
// registered before the front candidate is compared and the row shifts.
// Reset clears pointers, counts, candidate valid bits and the state machine.
// The receiver cannot stall; results are never held.
module max_tracking_fifo #(
    parameter int DEPTH      = mtf_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = mtf_pkg::VALUE_BITS_DEF,
    localparam int PTR_BITS  = $clog2(DEPTH),
    localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_op,
    input  logic [VALUE_BITS-1:0] i_push_value,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_popped_value,
    output logic                  o_pop_was_empty,
    output logic                  o_push_dropped,
    output logic [VALUE_BITS-1:0] o_current_max,
    output logic                  o_max_valid,
    output logic [CNT_BITS-1:0]   o_occupancy
);

    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [PTR_BITS-1:0]   r_rp, n_rp;
    logic [PTR_BITS-1:0]   r_wp, n_wp;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  r_done, n_done;
    logic [VALUE_BITS-1:0] r_popped, n_popped;
    logic                  r_was_empty, n_was_empty;
    logic                  r_dropped, n_dropped;
    logic [VALUE_BITS-1:0] r_rd_data;
    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    logic                  w_accept;
    logic                  w_wr_en;
    mtf_pkg::t_cell_cmd    w_cmd;
    logic [VALUE_BITS-1:0] w_front_value;
    logic                  w_front_valid;

    assign o_busy   = (r_state == S_POP);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_count     = r_count;
        n_done      = 1'b0;
        n_popped    = '0;
        n_was_empty = 1'b0;
        n_dropped   = 1'b0;
        w_wr_en     = 1'b0;
        w_cmd       = '{push: 1'b0, shift: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == mtf_pkg::OP_POP) begin
                        if (r_count == '0) begin
                            n_done      = 1'b1;
                            n_was_empty = 1'b1;
                        end else begin
                            n_state = S_POP;
                        end
                    end else begin
                        n_done = 1'b1;
                        if (r_count == CNT_FULL) begin
                            n_dropped = 1'b1;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_cmd.push = 1'b1;
                            n_wp      = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end
                end
            end
            S_POP: begin
                n_state     = S_IDLE;
                n_done      = 1'b1;
                n_popped    = r_rd_data;
                w_cmd.shift = w_front_valid && (w_front_value == r_rd_data);
                n_rp        = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
                n_count     = r_count - 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped    <= n_popped;
        r_was_empty <= n_was_empty;
        r_dropped   <= n_dropped;
    end

    // value ring: one write port, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wp] <= i_push_value;
        end
        r_rd_data <= r_mem[r_rp];
    end

    mtf_cand_chain #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_new_value   (i_push_value),
        .o_front_value (w_front_value),
        .o_front_valid (w_front_valid)
    );

    assign o_done          = r_done;
    assign o_popped_value  = r_popped;
    assign o_pop_was_empty = r_was_empty;
    assign o_push_dropped  = r_dropped;
    assign o_max_valid     = (r_count != '0);
    assign o_current_max   = (o_max_valid && w_front_valid) ? w_front_value : '0;
    assign o_occupancy     = r_count;

endmodule

[src/mtf_cell.sv]
// mtf_cell: one slot of the candidate row (value plus valid bit).
// Depends on mtf_pkg for the command struct.
module mtf_cell #(
    parameter int VALUE_BITS = mtf_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mtf_pkg::t_cell_cmd    i_cmd,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic                  i_left_keep,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_right_valid,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_valid,
    output logic                  o_keep
);

    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_valid, n_valid;

    assign o_keep = r_valid && !(r_value < i_new_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.push) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_value = i_new_value;
                    n_valid = 1'b1;
                end else begin
                    n_valid = 1'b0;
                end
            end
        end else if (i_cmd.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

[src/mtf_cand_chain.sv]
// mtf_cand_chain: row of DEPTH candidate cells, non-increasing from the front.
// Depends on mtf_pkg and mtf_cell.
module mtf_cand_chain #(
    parameter int DEPTH      = mtf_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = mtf_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mtf_pkg::t_cell_cmd    i_cmd,
    input  logic [VALUE_BITS-1:0] i_new_value,
    output logic [VALUE_BITS-1:0] o_front_value,
    output logic                  o_front_valid
);

    logic [VALUE_BITS-1:0] w_value [DEPTH+1];
    logic                  w_valid [DEPTH+1];
    logic                  w_keep  [DEPTH+1];

    assign w_keep[0]      = 1'b1;
    assign w_value[DEPTH] = '0;
    assign w_valid[DEPTH] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        mtf_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (i_cmd),
            .i_new_value   (i_new_value),
            .i_left_keep   (w_keep[gi]),
            .i_right_value (w_value[gi+1]),
            .i_right_valid (w_valid[gi+1]),
            .o_value       (w_value[gi]),
            .o_valid       (w_valid[gi]),
            .o_keep        (w_keep[gi+1])
        );
    end

    assign o_front_value = w_value[0];
    assign o_front_valid = w_valid[0];

endmodule
